/* sv/assert_macros.svh */
// assertion macros used by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define MWR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define MWR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/mwr_pkg.sv */
// types and constants of the ranged multiply-with-carry generator
// no dependencies
`timescale 1ns / 1ps

package mwr_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int CNT_W  = 5;

    localparam logic [HALF_W-1:0] MUL_Z = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_W = 16'd18000;

    localparam logic [WORD_W-1:0] SEED_Z_RESET = 32'd362436069;
    localparam logic [WORD_W-1:0] SEED_W_RESET = 32'd521288629;

    localparam logic REG_SEED_Z = 1'b0;
    localparam logic REG_SEED_W = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we_z;
        logic              we_w;
        logic [WORD_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* sv/mwr_gen.sv */
// seed registers and the two multiply-with-carry halves
// depends on mwr_pkg
`timescale 1ns / 1ps

module mwr_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwr_pkg::cfg_wr_t           cfg_wr,
    input  logic                       advance,
    output logic [mwr_pkg::WORD_W-1:0] seed_z,
    output logic [mwr_pkg::WORD_W-1:0] seed_w,
    output logic [mwr_pkg::WORD_W-1:0] word
);

    logic [mwr_pkg::WORD_W-1:0] seed_z_reg;
    logic [mwr_pkg::WORD_W-1:0] seed_w_reg;
    logic [mwr_pkg::WORD_W-1:0] z_reg;
    logic [mwr_pkg::WORD_W-1:0] w_reg;
    logic [mwr_pkg::WORD_W-1:0] z_next;
    logic [mwr_pkg::WORD_W-1:0] w_next;

    always_comb
    begin
        z_next = {{mwr_pkg::HALF_W{1'b0}}, mwr_pkg::MUL_Z}
                   * {{mwr_pkg::HALF_W{1'b0}}, z_reg[mwr_pkg::HALF_W-1:0]}
               + {{mwr_pkg::HALF_W{1'b0}}, z_reg[mwr_pkg::WORD_W-1:mwr_pkg::HALF_W]};
        w_next = {{mwr_pkg::HALF_W{1'b0}}, mwr_pkg::MUL_W}
                   * {{mwr_pkg::HALF_W{1'b0}}, w_reg[mwr_pkg::HALF_W-1:0]}
               + {{mwr_pkg::HALF_W{1'b0}}, w_reg[mwr_pkg::WORD_W-1:mwr_pkg::HALF_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_z_reg <= mwr_pkg::SEED_Z_RESET;
            seed_w_reg <= mwr_pkg::SEED_W_RESET;
            z_reg      <= mwr_pkg::SEED_Z_RESET;
            w_reg      <= mwr_pkg::SEED_W_RESET;
        end
        else
        begin
            if (cfg_wr.we_z)
            begin
                seed_z_reg <= cfg_wr.data;
                z_reg      <= cfg_wr.data;
            end
            else if (advance)
            begin
                z_reg <= z_next;
            end
            if (cfg_wr.we_w)
            begin
                seed_w_reg <= cfg_wr.data;
                w_reg      <= cfg_wr.data;
            end
            else if (advance)
            begin
                w_reg <= w_next;
            end
        end
    end

    // word from the advanced halves, read in the cycle after the advance
    assign word   = {z_reg[mwr_pkg::HALF_W-1:0], {mwr_pkg::HALF_W{1'b0}}} + w_reg;
    assign seed_z = seed_z_reg;
    assign seed_w = seed_w_reg;

endmodule

/* sv/mwr_div.sv */
// bit-serial restoring modulo, one dividend bit per cycle
// depends on mwr_pkg
`timescale 1ns / 1ps

module mwr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mwr_pkg::WORD_W-1:0] dividend,
    input  logic [mwr_pkg::WORD_W-1:0] divisor,
    output mwr_pkg::div_status_t       status,
    output logic [mwr_pkg::WORD_W-1:0] remainder
);

    logic [mwr_pkg::WORD_W-1:0] rem_reg;
    logic [mwr_pkg::WORD_W-1:0] rem_next;
    logic [mwr_pkg::WORD_W-1:0] shift_reg;
    logic [mwr_pkg::WORD_W-1:0] dvs_reg;
    logic [mwr_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [mwr_pkg::WORD_W:0]   trial;
    logic [mwr_pkg::WORD_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, shift_reg[mwr_pkg::WORD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[mwr_pkg::WORD_W])
        begin
            rem_next = diff[mwr_pkg::WORD_W-1:0];
        end
        else
        begin
            rem_next = trial[mwr_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= dividend;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[mwr_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

/* sv/mwc_random_range_core.sv */
// equal bounds or a wrapped span skip the serial modulo; other ranges pass through it
// one beat at a time: a new range is taken once the last result is loaded; the modulo has 32 steps
// reset: rst_n async active low; seeds and both halves take their reset seeds, no beat pending
// top level: apb seed registers, generator halves, serial modulo and output register
// depends on mwr_pkg, mwr_gen, mwr_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwc_random_range_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value
);

    mwr_pkg::state_t state_reg;
    mwr_pkg::state_t state_next;

    mwr_pkg::cfg_wr_t     cfg_wr;
    mwr_pkg::div_status_t div_stat;

    logic [mwr_pkg::WORD_W-1:0] seed_z;
    logic [mwr_pkg::WORD_W-1:0] seed_w;
    logic [mwr_pkg::WORD_W-1:0] word;
    logic [mwr_pkg::WORD_W-1:0] remainder;
    logic [mwr_pkg::WORD_W-1:0] span;
    logic [mwr_pkg::WORD_W-1:0] span_reg;
    logic [mwr_pkg::WORD_W-1:0] low_reg;
    logic [mwr_pkg::WORD_W-1:0] res_reg;
    logic [mwr_pkg::WORD_W-1:0] out_reg;
    logic                       out_valid_reg;
    logic                       in_beat;
    logic                       same_bounds;
    logic                       advance;
    logic                       div_start;
    logic                       out_load;
    logic                       out_free;
    logic                       wr_en;

    assign wr_en       = psel && penable && pwrite;
    assign cfg_wr.we_z = wr_en && (paddr[2] == mwr_pkg::REG_SEED_Z);
    assign cfg_wr.we_w = wr_en && (paddr[2] == mwr_pkg::REG_SEED_W);
    assign cfg_wr.data = pwdata;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == mwr_pkg::REG_SEED_W) ? seed_w : seed_z;

    assign in_beat     = in_valid && in_ready;
    assign same_bounds = (range_low == range_high);
    assign span        = range_high - range_low + 1'b1;
    assign out_free    = !out_valid_reg || out_ready;

    mwr_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .advance (advance),
        .seed_z  (seed_z),
        .seed_w  (seed_w),
        .word    (word)
    );

    mwr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (word),
        .divisor   (span_reg),
        .status    (div_stat),
        .remainder (remainder)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (same_bounds || (span == '0))
                    begin
                        state_next = mwr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = mwr_pkg::ST_START;
                    end
                end
            end
            mwr_pkg::ST_START:
            begin
                state_next = mwr_pkg::ST_DIV;
            end
            mwr_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = mwr_pkg::ST_DONE;
                end
            end
            mwr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mwr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mwr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        advance   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            mwr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                advance  = in_valid && !same_bounds;
            end
            mwr_pkg::ST_START:
            begin
                div_start = 1'b1;
            end
            mwr_pkg::ST_DIV:
            begin
            end
            mwr_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            low_reg  <= range_low;
            span_reg <= span;
            if (same_bounds)
            begin
                res_reg <= range_low;
            end
            else
            begin
                res_reg <= '0;
            end
        end
        else if ((state_reg == mwr_pkg::ST_DIV) && div_stat.done)
        begin
            res_reg <= remainder + low_reg;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_reg;

    `MWR_ASSERT(a_done_in_div, clk, rst_n, div_stat.done |-> (state_reg == mwr_pkg::ST_DIV), "modulo finished outside the divide state")
    `MWR_ASSERT(a_beat_blocks, clk, rst_n, in_beat |=> !in_ready, "second input beat taken before the first result")
    `MWR_ASSERT(a_load_shows, clk, rst_n, out_load |=> out_valid, "loaded result not offered")
    `MWR_ASSERT(a_start_busy, clk, rst_n, div_start |=> div_stat.busy, "modulo did not start")

endmodule

/* bench/mwr_range_checker.sv */
// checker for mwc_random_range_core: watches the apb port and both channels,
// predicts each value beat and compares; depends on mwr_pkg
`timescale 1ns / 1ps

module mwr_range_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] value,
    output logic [31:0]        fail_count,
    output logic [31:0]        pending
);

    localparam logic [2:0] SEED_Z_ADDR = {mwr_pkg::REG_SEED_Z, 2'b00};
    localparam logic [2:0] SEED_W_ADDR = {mwr_pkg::REG_SEED_W, 2'b00};

    logic [mwr_pkg::WORD_W-1:0] seed_z_copy = mwr_pkg::SEED_Z_RESET;
    logic [mwr_pkg::WORD_W-1:0] seed_w_copy = mwr_pkg::SEED_W_RESET;
    logic [mwr_pkg::WORD_W-1:0] z_copy = mwr_pkg::SEED_Z_RESET;
    logic [mwr_pkg::WORD_W-1:0] w_copy = mwr_pkg::SEED_W_RESET;
    logic [mwr_pkg::WORD_W-1:0] expected_values[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    // advances both halves unless the bounds are equal, then maps the word into the span (zero for a wrapped span)
    function automatic logic [mwr_pkg::WORD_W-1:0] draw_in_range(
        input logic [mwr_pkg::WORD_W-1:0] lo,
        input logic [mwr_pkg::WORD_W-1:0] hi);
        logic [mwr_pkg::WORD_W-1:0] word;
        logic [mwr_pkg::WORD_W-1:0] span;
        if (lo == hi)
            return lo;
        z_copy = mwr_pkg::MUL_Z * z_copy[mwr_pkg::HALF_W-1:0]
               + z_copy[mwr_pkg::WORD_W-1:mwr_pkg::HALF_W];
        w_copy = mwr_pkg::MUL_W * w_copy[mwr_pkg::HALF_W-1:0]
               + w_copy[mwr_pkg::WORD_W-1:mwr_pkg::HALF_W];
        word = {z_copy[mwr_pkg::HALF_W-1:0], {mwr_pkg::HALF_W{1'b0}}} + w_copy;
        span = hi - lo + 32'd1;
        if (span == '0)
            return '0;
        return (word % span) + lo;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [mwr_pkg::WORD_W-1:0] want;
        if (!rst_n)
        begin
            seed_z_copy = mwr_pkg::SEED_Z_RESET;
            seed_w_copy = mwr_pkg::SEED_W_RESET;
            z_copy = mwr_pkg::SEED_Z_RESET;
            w_copy = mwr_pkg::SEED_W_RESET;
            expected_values.delete();
            pending <= '0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == SEED_Z_ADDR)
                    begin
                        seed_z_copy = pwdata;
                        z_copy = pwdata;
                    end
                    else if (paddr == SEED_W_ADDR)
                    begin
                        seed_w_copy = pwdata;
                        w_copy = pwdata;
                    end
                end
                else
                begin
                    want = (paddr == SEED_Z_ADDR) ? seed_z_copy : seed_w_copy;
                    if (prdata !== want)
                        report_mismatch($sformatf("prdata at %0d: got %h, want %h",
                                                  paddr, prdata, want));
                end
            end
            if (in_valid && in_ready)
                expected_values.push_back(draw_in_range(range_low, range_high));
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("value beat %h with nothing expected", value));
                else
                begin
                    want = expected_values.pop_front();
                    if (value !== want)
                        report_mismatch($sformatf("value: got %h, want %h", value, want));
                end
            end
            pending <= expected_values.size();
        end
    end

endmodule

/* bench/tb_mwc_random_range_core.sv */
// testbench top for mwc_random_range_core: clock, reset, apb seed writes,
// range beats with bursts and stalls; depends on mwr_pkg, mwc_random_range_core and mwr_range_checker
`timescale 1ns / 1ps

module tb_mwc_random_range_core;

    localparam logic [2:0] SEED_Z_ADDR = {mwr_pkg::REG_SEED_Z, 2'b00};
    localparam logic [2:0] SEED_W_ADDR = {mwr_pkg::REG_SEED_W, 2'b00};
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam int PHASES = 6;
    localparam int BEATS_PER_PHASE = 190;
    localparam int RDY_FREE = 0;
    localparam int RDY_LIGHT = 1;
    localparam int RDY_HEAVY = 2;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] range_low = '0;
    logic signed [31:0] range_high = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] value;
    logic [31:0]        fail_count;
    logic [31:0]        pending;

    int burst_left = 0;
    int ready_mode = RDY_FREE;
    int mode_left = 0;

    always #5 clk = ~clk;

    mwc_random_range_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .range_low  (range_low),
        .range_high (range_high),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value)
    );

    mwr_range_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .range_low  (range_low),
        .range_high (range_high),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: free-running, light stalls or heavy stalls, switching at random
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(RDY_FREE, RDY_HEAVY);
            mode_left <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            RDY_FREE: out_ready <= 1'b1;
            RDY_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_seeds(input logic [31:0] z_seed, input logic [31:0] w_seed);
        apb_access(1'b1, SEED_Z_ADDR, z_seed);
        apb_access(1'b1, SEED_W_ADDR, w_seed);
        apb_access(1'b0, SEED_Z_ADDR, '0);
        apb_access(1'b0, SEED_W_ADDR, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        range_low <= lo;
        range_high <= hi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [31:0] lo;
        logic [31:0] hi;
        int pick;
        pick = $urandom_range(0, 99);
        lo = $urandom;
        hi = $urandom;
        if (pick < 10)
            hi = lo;
        else if (pick < 15)
        begin
            if ($urandom_range(0, 1))
            begin
                lo = INT_MIN;
                hi = INT_MAX;
            end
            else
                hi = lo - 32'd1;
        end
        else if (pick < 45)
            hi = lo + $urandom_range(1, 300);
        else if (pick < 60)
        begin
            if ($signed(lo) < $signed(hi))
                {lo, hi} = {hi, lo};
        end
        send_range(lo, hi);
    endtask

    initial
    begin
        logic [31:0] z_seed;
        logic [31:0] w_seed;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset seeds read back, then directed beats
        apb_access(1'b0, SEED_Z_ADDR, '0);
        apb_access(1'b0, SEED_W_ADDR, '0);
        send_range(32'd0, 32'd0);
        send_range(INT_MIN, INT_MIN);
        send_range(INT_MAX, INT_MAX);
        send_range(32'hffff_ffff, 32'hffff_ffff);
        send_range(INT_MIN, INT_MAX);
        send_range(32'd1, 32'd0);
        send_range(32'd0, 32'hffff_ffff);
        send_range(INT_MAX, INT_MIN);
        send_range(32'd5, 32'hffff_fffb);
        send_range(32'd0, 32'd1);
        send_range(32'hffff_ffff, 32'd0);
        send_range(32'd0, INT_MAX);
        send_range(INT_MIN, 32'd0);
        send_range(INT_MIN + 32'd1, INT_MAX);
        send_range(INT_MIN, INT_MAX - 32'd1);
        send_range(32'hffff_ff9c, 32'd100);
        send_range(32'd0, 32'h0000_ffff);
        send_range(32'h5555_5555, 32'haaaa_aaaa);
        send_range(32'haaaa_aaaa, 32'h5555_5555);
        send_range(INT_MIN, INT_MAX);
        send_range(32'd1, 32'd6);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0: begin z_seed = '0; w_seed = '0; end
                1: begin z_seed = '1; w_seed = '1; end
                2: begin z_seed = mwr_pkg::SEED_Z_RESET; w_seed = '0; end
                3: begin z_seed = 32'h0000_ffff; w_seed = 32'hffff_0000; end
                default: begin z_seed = $urandom; w_seed = $urandom; end
            endcase
            load_seeds(z_seed, w_seed);
            for (int i = 0; i < BEATS_PER_PHASE; i++)
                send_random();
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/mwr_pkg.sv
sv/mwr_gen.sv
sv/mwr_div.sv
sv/mwc_random_range_core.sv
bench/mwr_range_checker.sv
bench/tb_mwc_random_range_core.sv
